@@ rtl/core/pie_pkg.sv @@
`timescale 1ns / 1ps

package pie_pkg;

  // register file layout
  localparam int unsigned NumGroups  = 12;
  localparam int unsigned GroupW     = $clog2(NumGroups);
  localparam int unsigned PeriphMax  = 96;
  localparam int unsigned LastOffset = 'h19;

  // fixed register offsets on the bus
  localparam logic [4:0] OffCtrl = 5'd0;
  localparam logic [4:0] OffAck  = 5'd1;

  // message queue
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // command queue between decode and execute
  localparam int unsigned CmdqDepth = 2;
  localparam int unsigned CmdqPtrW  = $clog2(CmdqDepth);
  localparam int unsigned CmdqCntW  = $clog2(CmdqDepth + 1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RAISE = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_READ,
    CMD_WRITE,
    CMD_BAD,
    CMD_PERIPH,
    CMD_OTHER,
    CMD_TICK
  } cmd_kind_e;

  typedef enum logic [1:0] {
    REG_CTRL,
    REG_ACK,
    REG_EN,
    REG_FLAG
  } reg_sel_e;

  typedef struct packed {
    op_e         opcode;
    logic [4:0]  reg_offset;
    logic [15:0] write_data;
    logic [6:0]  irq_line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        bad_offset;
    logic        signal_valid;
    logic        signal_kind;
    logic [3:0]  signal_group;
    logic [2:0]  signal_bit;
    logic        queue_overflow;
  } out_item_t;

  // decoded command handed from the front to the back
  typedef struct packed {
    cmd_kind_e   kind;
    reg_sel_e    sel;
    logic [3:0]  grp;
    logic [2:0]  bit_idx;
    logic [15:0] wdata;
  } cmd_t;

  // queued interrupt message
  typedef struct packed {
    logic       kind;
    logic [3:0] grp;
    logic [2:0] bit_idx;
  } msg_t;

endpackage

@@ rtl/core/pie_front.sv @@
`timescale 1ns / 1ps

module pie_front (
  input  pie_pkg::in_item_t item_i,
  output pie_pkg::cmd_t     cmd_o
);

  logic [6:0] irq_m1;
  logic [4:0] off_half;

  assign irq_m1   = item_i.irq_line - 7'd1;
  assign off_half = item_i.reg_offset >> 1;

  // classify the transaction and work out register or group targets
  always_comb begin
    cmd_o         = '0;
    cmd_o.kind    = pie_pkg::CMD_NOP;
    cmd_o.sel     = pie_pkg::REG_CTRL;
    cmd_o.wdata   = item_i.write_data;
    case (item_i.opcode)
      pie_pkg::OP_READ, pie_pkg::OP_WRITE: begin
        cmd_o.kind = (item_i.opcode == pie_pkg::OP_READ) ? pie_pkg::CMD_READ
                                                         : pie_pkg::CMD_WRITE;
        if (item_i.reg_offset == pie_pkg::OffCtrl) begin
          cmd_o.sel = pie_pkg::REG_CTRL;
        end else if (item_i.reg_offset == pie_pkg::OffAck) begin
          cmd_o.sel = pie_pkg::REG_ACK;
        end else if (item_i.reg_offset > 5'(pie_pkg::LastOffset)) begin
          cmd_o.kind = pie_pkg::CMD_BAD;
        end else begin
          cmd_o.sel = item_i.reg_offset[0] ? pie_pkg::REG_FLAG : pie_pkg::REG_EN;
          cmd_o.grp = 4'(off_half - 5'd1);
        end
      end
      pie_pkg::OP_RAISE: begin
        if (item_i.irq_line == 7'd0) begin
          cmd_o.kind = pie_pkg::CMD_NOP;
        end else if (item_i.irq_line > 7'(pie_pkg::PeriphMax)) begin
          cmd_o.kind = pie_pkg::CMD_OTHER;
          cmd_o.grp  = item_i.irq_line[6:3] - 4'd1;
        end else begin
          cmd_o.kind    = pie_pkg::CMD_PERIPH;
          cmd_o.grp     = irq_m1[6:3];
          cmd_o.bit_idx = irq_m1[2:0];
        end
      end
      pie_pkg::OP_TICK: begin
        cmd_o.kind = pie_pkg::CMD_TICK;
      end
      default: begin
        cmd_o.kind = pie_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

@@ rtl/core/pie_cmd_fifo.sv @@
`timescale 1ns / 1ps

module pie_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pie_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pie_pkg::cmd_t pop_data_o
);

  pie_pkg::cmd_t                   mem_q [pie_pkg::CmdqDepth];
  logic [pie_pkg::CmdqPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [pie_pkg::CmdqPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [pie_pkg::CmdqCntW-1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == pie_pkg::CmdqCntW'(pie_pkg::CmdqDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == pie_pkg::CmdqPtrW'(pie_pkg::CmdqDepth - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == pie_pkg::CmdqPtrW'(pie_pkg::CmdqDepth - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/pie_back.sv @@
`timescale 1ns / 1ps

module pie_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  pie_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pie_pkg::out_item_t out_data_o
);

  logic [15:0] ctrl_q, ctrl_d;
  logic [15:0] ack_q, ack_d;
  logic [15:0] en_q [pie_pkg::NumGroups];
  logic [15:0] en_d [pie_pkg::NumGroups];
  logic [15:0] fl_q [pie_pkg::NumGroups];
  logic [15:0] fl_d [pie_pkg::NumGroups];

  pie_pkg::msg_t                  msg_q [pie_pkg::QueueDepth];
  logic [pie_pkg::QueuePtrW-1:0]  head_q, head_d;
  logic [pie_pkg::QueuePtrW-1:0]  tail_q, tail_d;
  logic [pie_pkg::QueueCntW-1:0]  count_q, count_d;

  logic                          out_valid_q;
  pie_pkg::out_item_t            out_q;
  pie_pkg::out_item_t            res;
  logic                          fire;
  logic                          push;
  pie_pkg::msg_t                 push_msg;
  pie_pkg::msg_t                 head_msg;
  logic                          q_full;
  logic [pie_pkg::GroupW-1:0]    gidx;
  logic [15:0]                   cur_en;
  logic [15:0]                   cur_fl;
  logic [15:0]                   bit_mask;

  assign fire        = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o   = fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign q_full   = (count_q == pie_pkg::QueueCntW'(pie_pkg::QueueDepth));
  assign head_msg = msg_q[head_q];
  assign gidx     = pie_pkg::GroupW'(cmd_i.grp);
  assign cur_en   = en_q[gidx];
  assign cur_fl   = fl_q[gidx];
  assign bit_mask = 16'd1 << cmd_i.bit_idx;

  // execute one command against the register file and message queue
  always_comb begin
    res      = '0;
    push     = 1'b0;
    push_msg = '0;
    ctrl_d   = ctrl_q;
    ack_d    = ack_q;
    en_d     = en_q;
    fl_d     = fl_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    case (cmd_i.kind)
      pie_pkg::CMD_READ: begin
        case (cmd_i.sel)
          pie_pkg::REG_CTRL: res.read_data = ctrl_q;
          pie_pkg::REG_ACK:  res.read_data = ack_q;
          pie_pkg::REG_EN:   res.read_data = cur_en;
          pie_pkg::REG_FLAG: res.read_data = cur_fl;
          default:           res.read_data = '0;
        endcase
      end
      pie_pkg::CMD_WRITE: begin
        case (cmd_i.sel)
          pie_pkg::REG_CTRL: ctrl_d       = cmd_i.wdata;
          pie_pkg::REG_ACK:  ack_d        = cmd_i.wdata;
          pie_pkg::REG_EN:   en_d[gidx]   = cmd_i.wdata;
          pie_pkg::REG_FLAG: fl_d[gidx]   = cmd_i.wdata;
          default:           ctrl_d       = ctrl_q;
        endcase
      end
      pie_pkg::CMD_BAD: begin
        res.bad_offset = 1'b1;
      end
      pie_pkg::CMD_PERIPH: begin
        fl_d[gidx] = cur_fl | bit_mask;
        if (ctrl_q[0] && ((cur_en & bit_mask) != '0)) begin
          ack_d            = ack_q | (16'd1 << cmd_i.grp);
          push_msg.kind    = 1'b0;
          push_msg.grp     = cmd_i.grp;
          push_msg.bit_idx = cmd_i.bit_idx;
          if (q_full) begin
            res.queue_overflow = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
      end
      pie_pkg::CMD_OTHER: begin
        push_msg.kind = 1'b1;
        push_msg.grp  = cmd_i.grp;
        if (q_full) begin
          res.queue_overflow = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
      pie_pkg::CMD_TICK: begin
        if (count_q != '0) begin
          res.signal_valid = 1'b1;
          res.signal_kind  = head_msg.kind;
          res.signal_group = head_msg.grp;
          res.signal_bit   = head_msg.kind ? 3'd0 : head_msg.bit_idx;
          head_d  = (head_q == pie_pkg::QueuePtrW'(pie_pkg::QueueDepth - 1)) ? '0
                                                                           : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
    if (push) begin
      tail_d  = (tail_q == pie_pkg::QueuePtrW'(pie_pkg::QueueDepth - 1)) ? '0
                                                                       : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
  end

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      ack_q   <= '0;
      en_q    <= '{default: '0};
      fl_q    <= '{default: '0};
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (fire) begin
      ctrl_q  <= ctrl_d;
      ack_q   <= ack_d;
      en_q    <= en_d;
      fl_q    <= fl_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // message storage
  always_ff @(posedge clk_i) begin
    if (fire && push) begin
      msg_q[tail_q] <= push_msg;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

endmodule

@@ rtl/core/peripheral_interrupt_expander.sv @@
`timescale 1ns / 1ps

// channel   direction   handshake                    payload
// input     in          in_valid_i / in_stall_o      in_data_i  (pie_pkg::in_item_t)
// output    out         out_valid_o / out_stall_i    out_data_o (pie_pkg::out_item_t)
//
// one transaction per cycle sustained while the output is not stalled; each produces exactly one result
// the accepting edge writes the command queue; the command executes into the output
// register when the back end pops it, which an output stall or older commands can delay
// reset clears register file, output valid and queue pointers; no clearing pass
// an output stall holds the result and backs up through the two-entry command queue

module peripheral_interrupt_expander (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pie_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pie_pkg::out_item_t out_data_o
);

  pie_pkg::cmd_t dec_cmd;
  pie_pkg::cmd_t q_cmd;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  // decode
  pie_front u_front (
    .item_i (in_data_i),
    .cmd_o  (dec_cmd)
  );

  // command queue
  pie_cmd_fifo u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (dec_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cmd)
  );

  // execute
  pie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
